[src/weighted_grid_distance_heuristic_assert.svh]
// Assertion macros for the distance estimate block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef WEIGHTED_GRID_DISTANCE_HEURISTIC_ASSERT_SVH
`define WEIGHTED_GRID_DISTANCE_HEURISTIC_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WGDH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wgdh: same-cycle check failed");
`define WGDH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wgdh: next-cycle check failed");
`else
`define WGDH_ASSERT_IMP(lbl, ante, cons)
`define WGDH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/wgdh_pkg.sv]
`timescale 1ns / 1ps

package wgdh_pkg;

  typedef enum logic [1:0] {
    METRIC_MANHATTAN = 2'd0,
    METRIC_EUCLID    = 2'd1,
    METRIC_DIAGONAL  = 2'd2
  } metric_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd3;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned WEIGHT_W  = 12;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned OUT_W     = 23;
  localparam int unsigned DIAG_W    = 15;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 12'd256;
  localparam logic [DIAG_W-1:0]   DIAG_FRAC_Q16 = 15'd27146;
  localparam logic [OUT_W-1:0]    OUT_MAX       = 23'h7FFFFF;

endpackage

[src/wgdh_cell_if.sv]
`timescale 1ns / 1ps

interface wgdh_cell_if #(
  parameter int unsigned COORD_BITS = 10
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cell_col;
  logic [COORD_BITS-1:0] cell_row;

  modport source (output valid, output cell_col, output cell_row, input ready);
  modport sink (input valid, input cell_col, input cell_row, output ready);
endinterface

[src/wgdh_est_if.sv]
`timescale 1ns / 1ps

interface wgdh_est_if
  import wgdh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] estimate_q8;

  modport source (output valid, output estimate_q8, input ready);
  modport sink (input valid, input estimate_q8, output ready);
endinterface

[src/wgdh_front.sv]
`timescale 1ns / 1ps

// Two stages: absolute deltas, then the squared radicand and the
// non-Euclidean distance in Q.8.
module wgdh_front
  import wgdh_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  wgdh_cell_if.sink                 cell_i,
  input  logic [COORD_BITS-1:0]     goal_col_i,
  input  logic [COORD_BITS-1:0]     goal_row_i,
  input  logic [MODE_W-1:0]         mode_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [2*COORD_BITS+17:0]  rad_o,
  output logic [COORD_BITS+8:0]     halt_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned H_W  = C + 9;
  localparam int unsigned RW   = 2 * H_W;
  localparam int unsigned SQ_W = 2 * C + 1;
  localparam int unsigned DP_W = C + DIAG_W;

  logic          va_q, vb_q;
  logic          rdy_a, rdy_b;
  logic [C-1:0]  dx_d, dy_d, dx_q, dy_q;
  logic [C-1:0]  big, lil;
  logic [2*C-1:0] dx2, dy2;
  logic [SQ_W-1:0] sq_sum;
  logic [DP_W-1:0] diag_p;
  logic [H_W-1:0]  h_d, h_q;
  logic [RW-1:0]   rad_d, rad_q;

  assign rdy_b        = !vb_q || ready_i;
  assign rdy_a        = !va_q || rdy_b;
  assign cell_i.ready = rdy_a;

  always_comb begin
    dx_d = (cell_i.cell_col >= goal_col_i) ? cell_i.cell_col - goal_col_i
                                           : goal_col_i - cell_i.cell_col;
    dy_d = (cell_i.cell_row >= goal_row_i) ? cell_i.cell_row - goal_row_i
                                           : goal_row_i - cell_i.cell_row;
  end

  always_comb begin
    dx2    = dx_q * dx_q;
    dy2    = dy_q * dy_q;
    sq_sum = SQ_W'(dx2) + SQ_W'(dy2);
    rad_d  = RW'(sq_sum) << (2 * FRAC_BITS);
    big    = (dx_q > dy_q) ? dx_q : dy_q;
    lil    = (dx_q > dy_q) ? dy_q : dx_q;
    diag_p = DP_W'(lil) * DP_W'(DIAG_FRAC_Q16);
    unique case (metric_e'(mode_i))
      METRIC_DIAGONAL: begin
        h_d = (H_W'(big) << FRAC_BITS) + H_W'(diag_p[DP_W-1:FRAC_BITS]);
      end
      default: begin
        // Euclidean items carry this too; the back end picks the root instead.
        h_d = H_W'(H_W'(dx_q) + H_W'(dy_q)) << FRAC_BITS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= cell_i.valid;
      if (rdy_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && cell_i.valid) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (rdy_b && va_q) begin
      rad_q <= rad_d;
      h_q   <= h_d;
    end
  end

  assign valid_o = vb_q;
  assign rad_o   = rad_q;
  assign halt_o  = h_q;

endmodule

[src/wgdh_sqrt_cell.sv]
`timescale 1ns / 1ps

// One restoring square-root step: two radicand bits in, one root bit out.
module wgdh_sqrt_cell #(
  parameter int unsigned ROOT_W = 19
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [2*ROOT_W-1:0] rad_i,
  input  logic [ROOT_W+1:0]   rem_i,
  input  logic [ROOT_W-1:0]   root_i,
  input  logic [ROOT_W-1:0]   halt_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [2*ROOT_W-1:0] rad_o,
  output logic [ROOT_W+1:0]   rem_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [ROOT_W-1:0]   halt_o
);

  localparam int unsigned RW    = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CMP_W = REM_W + 2;

  logic             valid_q;
  logic [CMP_W-1:0] rem_sh, trial, rem_sub;
  logic             take;
  logic [RW-1:0]    rad_d, rad_q;
  logic [REM_W-1:0] rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q, halt_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rem_sh  = {rem_i, rad_i[RW-1:RW-2]};
    trial   = CMP_W'({root_i, 2'b01});
    take    = rem_sh >= trial;
    rem_sub = rem_sh - trial;
    rem_d   = take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_d  = {root_i[ROOT_W-2:0], take};
    rad_d   = {rad_i[RW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      halt_q <= halt_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign halt_o  = halt_q;

endmodule

[src/wgdh_back.sv]
`timescale 1ns / 1ps

// Metric select and weight multiply, then truncation to Q.8 and saturation.
module wgdh_back
  import wgdh_pkg::*;
#(
  parameter int unsigned H_W = 19
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [H_W-1:0]      root_i,
  input  logic [H_W-1:0]      halt_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  wgdh_est_if.source          est_o
);

  localparam int unsigned PROD_W = H_W + WEIGHT_W;
  localparam int unsigned SH_W   = PROD_W - FRAC_BITS;
  localparam int unsigned EXT_W  = (SH_W > OUT_W) ? SH_W : OUT_W;

  logic              vp_q, vo_q;
  logic              rdy_p, rdy_o;
  logic [H_W-1:0]    h_sel;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [EXT_W-1:0]  sh_ext;
  logic [OUT_W-1:0]  est_d, est_q;

  assign rdy_o   = !vo_q || est_o.ready;
  assign rdy_p   = !vp_q || rdy_o;
  assign ready_o = rdy_p;

  always_comb begin
    h_sel  = (metric_e'(mode_i) == METRIC_EUCLID) ? root_i : halt_i;
    prod_d = PROD_W'(h_sel) * PROD_W'(weight_i);
    sh_ext = EXT_W'(prod_q[PROD_W-1:FRAC_BITS]);
    est_d  = (sh_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : sh_ext[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_p) vp_q <= valid_i;
      if (rdy_o) vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p && valid_i) prod_q <= prod_d;
    if (rdy_o && vp_q)    est_q  <= est_d;
  end

  assign est_o.valid       = vo_q;
  assign est_o.estimate_q8 = est_q;

endmodule

[src/weighted_grid_distance_heuristic.sv]
`timescale 1ns / 1ps
// Weighted grid distance estimate. Each item on cell_i carries a cell's column
// and row; the block returns one item on est_o holding the distance from that
// cell to the configured goal, in unsigned Q.8, times the Q4.8 weight and
// saturated at 2^23 - 1. Manhattan, exact floor-Euclidean and octile
// (diagonal) metrics are selectable; metric code 3 acts as Manhattan. The
// block takes one item every cycle unless every stage is full and est_o
// stalls, and holds up to COORD_BITS + 13 items in flight: COORD_BITS + 9
// cells of the square-root chain, which resolves one root bit per cell,
// plus two front stages (deltas, squares) and two back stages (weight
// multiply, saturation). Every stage stalls on its own, so an empty stage
// still takes an item while a result waits on est_o. Registers are written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i, and must only be changed while
// no item is in flight; the Euclidean root and the mode's Manhattan or
// diagonal distance are computed for every item, and the registered mode
// and weight are sampled by the stages as the item passes.
`include "weighted_grid_distance_heuristic_assert.svh"

module weighted_grid_distance_heuristic
  import wgdh_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [((COORD_BITS > WEIGHT_W) ? COORD_BITS : WEIGHT_W)-1:0] cfg_wdata_i,
  wgdh_cell_if.sink            cell_i,
  wgdh_est_if.source           est_o
);

  // Root width: the radicand (dx^2 + dy^2) << 16 has at most 2*COORD_BITS + 17
  // bits, so its root fits in COORD_BITS + 9 bits, which is also the width of
  // the Manhattan and diagonal distances in Q.8.
  localparam int unsigned N     = COORD_BITS + 9;
  localparam int unsigned RW    = 2 * N;
  localparam int unsigned REM_W = N + 2;

  // Configuration registers.
  logic [COORD_BITS-1:0] goal_col_q, goal_row_q;
  logic [MODE_W-1:0]     mode_q;
  logic [WEIGHT_W-1:0]   weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_col_q <= '0;
      goal_row_q <= '0;
      mode_q     <= METRIC_MANHATTAN;
      weight_q   <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GOAL_COL: goal_col_q <= cfg_wdata_i[COORD_BITS-1:0];
        REG_GOAL_ROW: goal_row_q <= cfg_wdata_i[COORD_BITS-1:0];
        REG_METRIC:   mode_q     <= cfg_wdata_i[MODE_W-1:0];
        REG_WEIGHT:   weight_q   <= cfg_wdata_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Links of the cell chain: position 0 is the front end's output, position N
  // the last cell's output.
  logic [N:0]       sq_vld, sq_rdy;
  logic [RW-1:0]    sq_rad  [N+1];
  logic [REM_W-1:0] sq_rem  [N+1];
  logic [N-1:0]     sq_root [N+1];
  logic [N-1:0]     sq_halt [N+1];

  wgdh_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_i),
    .goal_col_i (goal_col_q),
    .goal_row_i (goal_row_q),
    .mode_i     (mode_q),
    .valid_o    (sq_vld[0]),
    .ready_i    (sq_rdy[0]),
    .rad_o      (sq_rad[0]),
    .halt_o     (sq_halt[0])
  );

  // The root and the partial remainder start from zero for every item.
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    wgdh_sqrt_cell #(
      .ROOT_W (N)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld[k]),
      .ready_o (sq_rdy[k]),
      .rad_i   (sq_rad[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .halt_i  (sq_halt[k]),
      .valid_o (sq_vld[k+1]),
      .ready_i (sq_rdy[k+1]),
      .rad_o   (sq_rad[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .halt_o  (sq_halt[k+1])
    );
  end

  wgdh_back #(
    .H_W (N)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_vld[N]),
    .ready_o  (sq_rdy[N]),
    .root_i   (sq_root[N]),
    .halt_i   (sq_halt[N]),
    .mode_i   (mode_q),
    .weight_i (weight_q),
    .est_o    (est_o)
  );

  // A finished root leaves a remainder of at most twice the root.
  logic [REM_W-1:0] root_x2;
  assign root_x2 = REM_W'(sq_root[N]) << 1;

  // The input can only be refused when every stage is full and the result
  // on the output is not being taken.
  `WGDH_ASSERT_IMP(a_stall_source, !cell_i.ready, est_o.valid && !est_o.ready)
  // The last cell always hands over a consistent root and remainder.
  `WGDH_ASSERT_IMP(a_root_rem, sq_vld[N], sq_rem[N] <= root_x2)
  // A root blocked at the end of the chain stays put until the back end takes it.
  `WGDH_ASSERT_NEXT(a_root_hold, sq_vld[N] && !sq_rdy[N], sq_vld[N] && $stable(sq_root[N]))

endmodule
